// ----- sv/ssfmt_pkg.sv -----
// Package for the seven-segment triple number formatter.
// Holds widths, the digit-to-segment table and the decimal split helpers.
// It depends on nothing; every module of the block imports it.
`default_nettype none

package ssfmt_pkg;

    localparam int NUM_POSITIONS = 16;
    localparam int NUM_DIGITS    = NUM_POSITIONS / 2;
    localparam int POS_W         = $clog2(NUM_POSITIONS);

    localparam int LEFT_W   = 8;
    localparam int CENTER_W = 10;
    localparam int RIGHT_W  = 10;
    localparam int RING_W   = 3;
    localparam int SEG_W    = 8;

    localparam int IN_BITS      = LEFT_W + CENTER_W + RIGHT_W + RING_W + 2;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = POS_W + SEG_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [LEFT_W-1:0]   LEFT_MAX   = LEFT_W'(99);
    localparam logic [CENTER_W-1:0] CENTER_MAX = CENTER_W'(999);
    localparam logic [RIGHT_W-1:0]  RIGHT_MAX  = RIGHT_W'(999);
    localparam logic [SEG_W-1:0]    SEG_DP     = 8'h80;
    localparam logic [SEG_W-1:0]    SEG_BLANK  = 8'h00;

    typedef logic [3:0]       digit_t;
    typedef logic [SEG_W-1:0] seg_t;
    typedef seg_t [NUM_DIGITS-1:0] codes_t;

    // Hundreds digit and the remainder below one hundred.
    typedef struct packed {
        digit_t     hund;
        logic [6:0] rem;
    } hsplit_t;

    typedef struct packed {
        digit_t tens;
        digit_t units;
    } tsplit_t;

    // Controls handed from the sequencer to every cell of the chain.
    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctrl_t;

    function automatic seg_t seg_code(input digit_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h27;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Values up to 1023; the caller has already replaced values above 999 with zero.
    function automatic hsplit_t split_hundreds(input logic [9:0] v);
        hsplit_t    r;
        logic [9:0] base;
        r.hund = '0;
        base   = '0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 10'(k * 100)) begin
                r.hund = 4'(k);
                base   = 10'(k * 100);
            end
        end
        r.rem = 7'(v - base);
        return r;
    endfunction

    // Values below one hundred.
    function automatic tsplit_t split_tens(input logic [6:0] v);
        tsplit_t    r;
        logic [6:0] base;
        r.tens = '0;
        base   = '0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 7'(k * 10)) begin
                r.tens = 4'(k);
                base   = 7'(k * 10);
            end
        end
        r.units = 4'(v - base);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ssfmt_split.sv -----
// Front stage of the formatter: holds one accepted item, out-of-range values zeroed, split.
// Produces the eight digit codes with blanking and decimal points applied.
// Depends on ssfmt_pkg.
`default_nettype none

module ssfmt_split (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ssfmt_pkg::LEFT_W-1:0]   left_value,
    input  wire logic [ssfmt_pkg::CENTER_W-1:0] center_value,
    input  wire logic [ssfmt_pkg::RIGHT_W-1:0]  right_value,
    input  wire logic [ssfmt_pkg::RING_W-1:0]   ring_level,
    input  wire logic                          right_indicator,
    input  wire logic                          left_indicator,
    output logic                               out_valid,
    input  wire logic                          out_take,
    output ssfmt_pkg::codes_t                  out_codes
);
    import ssfmt_pkg::*;

    logic          valid_reg, valid_next;
    logic [6:0]    left_reg;
    hsplit_t       center_reg, right_reg;
    logic [RING_W-1:0] ring_reg;
    logic          rind_reg, lind_reg;

    logic [CENTER_W-1:0] center_clamped;
    logic [RIGHT_W-1:0]  right_clamped;
    logic [6:0]          left_clamped;
    logic                accept;

    tsplit_t center_t, right_t, left_t;
    logic    center_h_blank, right_h_blank;

    assign in_ready  = !valid_reg || out_take;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;

    assign center_clamped = (center_value > CENTER_MAX) ? '0 : center_value;
    assign right_clamped  = (right_value > RIGHT_MAX) ? '0 : right_value;
    assign left_clamped   = (left_value > LEFT_MAX) ? '0 : left_value[6:0];

    always_comb begin
        priority if (accept) begin
            valid_next = 1'b1;
        end else if (out_take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg   <= left_clamped;
            center_reg <= split_hundreds(center_clamped);
            right_reg  <= split_hundreds(right_clamped);
            ring_reg   <= ring_level;
            rind_reg   <= right_indicator;
            lind_reg   <= left_indicator;
        end
    end

    assign center_t      = split_tens(center_reg.rem);
    assign right_t       = split_tens(right_reg.rem);
    assign left_t        = split_tens(left_reg);
    assign center_h_blank = (center_reg.hund == 4'd0);
    assign right_h_blank  = (right_reg.hund == 4'd0);

    // A leading digit is blanked while every digit above it is zero too.
    always_comb begin
        out_codes[0] = center_h_blank ? SEG_BLANK : seg_code(center_reg.hund);
        out_codes[1] = (center_h_blank && center_t.tens == 4'd0) ?
                       SEG_BLANK : seg_code(center_t.tens);
        out_codes[2] = seg_code(center_t.units);
        out_codes[3] = (left_t.tens == 4'd0) ? SEG_BLANK : seg_code(left_t.tens);
        out_codes[4] = seg_code(left_t.units);
        out_codes[5] = right_h_blank ? SEG_BLANK : seg_code(right_reg.hund);
        out_codes[6] = (right_h_blank && right_t.tens == 4'd0) ?
                       SEG_BLANK : seg_code(right_t.tens);
        out_codes[7] = seg_code(right_t.units);

        for (int k = 0; k < 6; k++) begin
            if (ring_reg > RING_W'(k)) begin
                out_codes[k] = out_codes[k] | SEG_DP;
            end
        end
        if (rind_reg) begin
            out_codes[6] = out_codes[6] | SEG_DP;
        end
        if (lind_reg) begin
            out_codes[7] = out_codes[7] | SEG_DP;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ssfmt_cell.sv -----
// One cell of the output chain: holds the segment code of one display digit.
// Loads in parallel or takes its neighbor's code on a shift. Depends on ssfmt_pkg.
`default_nettype none

module ssfmt_cell (
    input  wire logic                   aclk,
    input  wire ssfmt_pkg::chain_ctrl_t ctrl,
    input  wire ssfmt_pkg::seg_t        load_code,
    input  wire ssfmt_pkg::seg_t        shift_in,
    output ssfmt_pkg::seg_t             code
);
    import ssfmt_pkg::*;

    seg_t code_reg, code_next;

    always_comb begin
        priority if (ctrl.load) begin
            code_next = load_code;
        end else if (ctrl.shift) begin
            code_next = shift_in;
        end else begin
            code_next = code_reg;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

`default_nettype wire

// ----- sv/seven_segment_triple_number_formatter.sv -----
// Seven-segment triple number formatter, top level; uses ssfmt_pkg,
// ssfmt_split (front stage) and ssfmt_cell (output chain).
// With the chain idle, an accepted item is first registered in the front stage and then
// loaded into the chain cells, where cell 0 presents its first result.
// Each item gives sixteen results on the single result channel, one per cycle while
// m_tready is high; the front stage can take the next item while these shift out.
// Reset (aresetn low at a clock edge) empties the front stage and the chain.
`default_nettype none

module seven_segment_triple_number_formatter (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input items.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0 up: left_value[7:0], center_value[9:0], right_value[9:0],
    // ring_level[2:0], right_indicator, left_indicator, zero fill.
    input  wire logic [ssfmt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Result items.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // Fields from bit 0 up: position[3:0], segments[7:0], zero fill.
    output logic [ssfmt_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                    m_tlast
);
    import ssfmt_pkg::*;

    // Unpacked view of the input item.
    logic [LEFT_W-1:0]   left_value;
    logic [CENTER_W-1:0] center_value;
    logic [RIGHT_W-1:0]  right_value;
    logic [RING_W-1:0]   ring_level;
    logic                right_indicator;
    logic                left_indicator;

    localparam int CENTER_LSB = LEFT_W;
    localparam int RIGHT_LSB  = CENTER_LSB + CENTER_W;
    localparam int RING_LSB   = RIGHT_LSB + RIGHT_W;
    localparam int RIND_BIT   = RING_LSB + RING_W;
    localparam int LIND_BIT   = RIND_BIT + 1;

    assign left_value      = s_tdata[LEFT_W-1:0];
    assign center_value    = s_tdata[RIGHT_LSB-1:CENTER_LSB];
    assign right_value     = s_tdata[RING_LSB-1:RIGHT_LSB];
    assign ring_level      = s_tdata[RIND_BIT-1:RING_LSB];
    assign right_indicator = s_tdata[RIND_BIT];
    assign left_indicator  = s_tdata[LIND_BIT];

    // The front stage holds the next item while the chain still shifts out the
    // current one, so the input side only waits once an item is already held there.
    logic   split_valid;
    logic   split_take;
    codes_t split_codes;

    ssfmt_split u_split (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .left_value      (left_value),
        .center_value    (center_value),
        .right_value     (right_value),
        .ring_level      (ring_level),
        .right_indicator (right_indicator),
        .left_indicator  (left_indicator),
        .out_valid       (split_valid),
        .out_take        (split_take),
        .out_codes       (split_codes)
    );

    // Sequencer for the chain. Cell 0 always drives the result; every digit is
    // shown on two positions, so the chain moves one cell on each odd position but the last.
    logic             busy_reg, busy_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             out_hs;
    logic             last_pos;
    logic             chain_free;
    chain_ctrl_t      ctrl;

    assign out_hs     = busy_reg && m_tready;
    assign last_pos   = (pos_reg == POS_W'(NUM_POSITIONS - 1));
    assign chain_free = !busy_reg || (out_hs && last_pos);
    assign split_take = split_valid && chain_free;

    always_comb begin
        ctrl.load  = split_take;
        ctrl.shift = out_hs && pos_reg[0] && !last_pos;
    end

    always_comb begin
        priority if (ctrl.load) begin
            busy_next = 1'b1;
            pos_next  = '0;
        end else if (out_hs) begin
            busy_next = !last_pos;
            pos_next  = pos_reg + POS_W'(1);
        end else begin
            busy_next = busy_reg;
            pos_next  = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    // The chain of cells; the last cell takes a blank code on a shift.
    seg_t cell_code [NUM_DIGITS];

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        seg_t shift_in;
        if (i == NUM_DIGITS - 1) begin : g_end
            assign shift_in = SEG_BLANK;
        end else begin : g_mid
            assign shift_in = cell_code[i+1];
        end
        ssfmt_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .load_code (split_codes[i]),
            .shift_in  (shift_in),
            .code      (cell_code[i])
        );
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last_pos;
    assign m_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), cell_code[0], pos_reg};

    // A load always restarts the position count with the chain marked busy.
    a_load_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |=> (busy_reg && pos_reg == '0))
        else $error("chain load did not restart at position zero");

    // On an odd position that is not the last, the next digit moves into cell 0.
    a_shift_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_hs && pos_reg[0] && !last_pos) |=> (cell_code[0] == $past(cell_code[1])))
        else $error("chain did not advance to the next digit");

    // An even position repeats the same digit code on the following position.
    a_even_repeats: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_hs && !pos_reg[0]) |=> (m_tvalid && $stable(cell_code[0])))
        else $error("digit was not repeated on its second position");

    // While the front stage is empty, s_tready is always high, so an offered item is taken.
    a_front_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !split_valid |-> s_tready)
        else $error("front stage refused an item while empty");

    // The run only ends after the last position has been taken.
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !busy_next) |-> (out_hs && last_pos))
        else $error("run ended before the last position");

endmodule

`default_nettype wire
